// ===== rtl/adaptive_line_sensor_detector_defines.svh =====
// Assertion macros for the adaptive line sensor detector.
// Included by adaptive_line_sensor_detector.sv, the RTL file that carries concurrent checks; needs nothing else.
`ifndef ADAPTIVE_LINE_SENSOR_DETECTOR_DEFINES_SVH
`define ADAPTIVE_LINE_SENSOR_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define ALSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ALSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/alsd_pkg.sv =====
// Shared types, constants and arithmetic helpers of the adaptive line sensor detector.
// Used by the channel interfaces and by every RTL module; depends on nothing.
`default_nettype none

package alsd_pkg;

	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned INDEX_W   = 2;
	localparam int unsigned READ_W    = 10;
	localparam int unsigned THR_W     = 10;
	localparam int unsigned BG_W      = 15;
	localparam int unsigned SUM_W     = READ_W + 2;

	localparam logic [BG_W-1:0]  BG_MAX          = {BG_W{1'b1}};
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(50);

	localparam int unsigned CAL_READS_DEFAULT    = 32;
	localparam int unsigned SENSOR_COUNT_DEFAULT = 3;

	// The blend (9*bg + sum/3)/10 equals (27*bg + sum)/30 exactly.
	localparam int unsigned BLEND_NUM   = 27;
	localparam int unsigned BLEND_DEN   = 30;
	localparam int unsigned BLEND_W     = 20;
	localparam int unsigned DIV30_SHIFT = 25;
	localparam int unsigned DIV30_MULT  = ((2 ** DIV30_SHIFT) + BLEND_DEN - 1) / BLEND_DEN;
	localparam int unsigned DIV30_PW    = BLEND_W + DIV30_SHIFT;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_CAL    = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_DETECT = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [INDEX_W-1:0] sensor_index;
		logic [READ_W-1:0]  reading_first;
		logic [READ_W-1:0]  reading_second;
		logic [READ_W-1:0]  reading_third;
	} item_t;

	typedef struct packed {
		logic            line_found;
		logic [BG_W-1:0] background_level;
	} result_t;

	// New background after a detect without a line, by reciprocal multiplication.
	function automatic logic [BG_W-1:0] blend_level(input logic [BG_W-1:0] bg,
			input logic [SUM_W-1:0] sum);
		logic [BLEND_W-1:0]  mix;
		logic [DIV30_PW-1:0] prod;
		mix  = BLEND_W'(bg) * BLEND_W'(BLEND_NUM) + BLEND_W'(sum);
		prod = DIV30_PW'(mix) * DIV30_PW'(DIV30_MULT);
		return prod[DIV30_SHIFT +: BG_W];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/alsd_item_if.sv =====
// Input item channel: valid/ready handshake with the sensor action and readings.
// Depends on alsd_pkg for field widths.
`default_nettype none

interface alsd_item_if import alsd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  sensor_index;
	logic [READ_W-1:0]   reading_first;
	logic [READ_W-1:0]   reading_second;
	logic [READ_W-1:0]   reading_third;

	modport source (output valid, output action, output sensor_index, output reading_first,
		output reading_second, output reading_third, input ready);
	modport sink (input valid, input action, input sensor_index, input reading_first,
		input reading_second, input reading_third, output ready);
endinterface

`default_nettype wire

// ===== rtl/alsd_result_if.sv =====
// Result item channel: valid/ready handshake with line flag and background level.
// Depends on alsd_pkg for field widths.
`default_nettype none

interface alsd_result_if import alsd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            line_found;
	logic [BG_W-1:0] background_level;

	modport source (output valid, output line_found, output background_level, input ready);
	modport sink (input valid, input line_found, input background_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/alsd_cfg_if.sv =====
// Configuration write channel carrying the line threshold register.
// Depends on alsd_pkg for the register width.
`default_nettype none

interface alsd_cfg_if import alsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] line_threshold;

	modport source (output valid, output line_threshold, input ready);
	modport sink (input valid, input line_threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/alsd_calc.sv =====
// Combinational step logic: next background of every sensor and the result of one item.
// Depends on alsd_pkg.
`default_nettype none

module alsd_calc import alsd_pkg::*; #(
	parameter int unsigned CAL_READS    = CAL_READS_DEFAULT,
	parameter int unsigned SENSOR_COUNT = SENSOR_COUNT_DEFAULT
) (
	input  item_t            item_s1,
	input  logic [THR_W-1:0] threshold,
	input  logic [BG_W-1:0]  bg_cur [SENSOR_COUNT],
	output logic [BG_W-1:0]  bg_nxt [SENSOR_COUNT],
	output result_t          res
);

	// Division by the calibration count as a reciprocal multiply, exact for 15-bit values.
	localparam int unsigned CAL_SHIFT = BG_W + $clog2(CAL_READS);
	localparam int unsigned CAL_MULT  = ((2 ** CAL_SHIFT) + CAL_READS - 1) / CAL_READS;
	localparam int unsigned CAL_PW    = BG_W + CAL_SHIFT + 1;
	localparam int unsigned CMP_W     = BG_W + 4;

	logic                    idx_ok;
	logic [SENSOR_COUNT-1:0] hit;
	logic [BG_W-1:0]         sel_bg;
	logic [SUM_W-1:0]        sum;
	logic [BG_W:0]           cal_sum;
	logic [BG_W-1:0]         cal_val;
	logic [BG_W-1:0]         blend_val;
	logic signed [CMP_W-1:0] bg_s;
	logic signed [CMP_W-1:0] thr_s;
	logic signed [CMP_W-1:0] sum_s;
	logic signed [CMP_W-1:0] diff;
	logic signed [CMP_W-1:0] triple;
	logic                    line_raw;
	logic [BG_W-1:0]         fin_val [SENSOR_COUNT];
	logic [CAL_PW-1:0]       fin_prod [SENSOR_COUNT];
	logic [BG_W-1:0]         sel_nxt;

	always_comb begin
		idx_ok = int'(item_s1.sensor_index) < int'(SENSOR_COUNT);
		sel_bg = '0;
		for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
			hit[i] = int'(item_s1.sensor_index) == i;
			if (hit[i]) begin
				sel_bg = sel_bg | bg_cur[i];
			end
			fin_prod[i] = CAL_PW'(bg_cur[i]) * CAL_PW'(CAL_MULT);
			fin_val[i]  = fin_prod[i][CAL_SHIFT +: BG_W];
		end

		sum = SUM_W'(item_s1.reading_first) + SUM_W'(item_s1.reading_second)
			+ SUM_W'(item_s1.reading_third);

		cal_sum = {1'b0, sel_bg} + (BG_W + 1)'(item_s1.reading_first);
		cal_val = cal_sum[BG_W] ? BG_MAX : cal_sum[BG_W-1:0];

		// background - floor(sum/3) > threshold holds exactly when 3*(background - threshold) > sum.
		bg_s     = CMP_W'(sel_bg);
		thr_s    = CMP_W'(threshold);
		sum_s    = CMP_W'(sum);
		diff     = bg_s - thr_s;
		triple   = diff + (diff <<< 1);
		line_raw = triple > sum_s;

		blend_val = blend_level(sel_bg, sum);

		for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
			bg_nxt[i] = bg_cur[i];
			case (item_s1.action)
				ACT_CLEAR: begin
					bg_nxt[i] = '0;
				end
				ACT_CAL: begin
					if (hit[i]) begin
						bg_nxt[i] = cal_val;
					end
				end
				ACT_FINISH: begin
					bg_nxt[i] = fin_val[i];
				end
				ACT_DETECT: begin
					if (hit[i] && !line_raw) begin
						bg_nxt[i] = blend_val;
					end
				end
				default: begin
					bg_nxt[i] = bg_cur[i];
				end
			endcase
		end

		sel_nxt = '0;
		for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
			if (hit[i]) begin
				sel_nxt = sel_nxt | bg_nxt[i];
			end
		end

		res.line_found       = idx_ok && (item_s1.action == ACT_DETECT) && line_raw;
		res.background_level = idx_ok ? sel_nxt : '0;
	end

endmodule

`default_nettype wire

// ===== rtl/alsd_out_stage.sv =====
// Result register in front of the result channel; the step logic stalls while an item
// waits in it to be taken. Depends on alsd_pkg and alsd_result_if.
`default_nettype none

module alsd_out_stage import alsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_res,
	alsd_result_if.source result
);

	logic    valid_q;
	result_t res_q;

	assign in_ready = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign result.valid            = valid_q;
	assign result.line_found       = res_q.line_found;
	assign result.background_level = res_q.background_level;

endmodule

`default_nettype wire

// ===== rtl/adaptive_line_sensor_detector.sv =====
// Path: an accepted item is held in the input register, and its result then in the result
// register of alsd_out_stage. Throughput: one item per cycle while the result channel is
// ready; the backgrounds are read, updated and written back between the two registers.
// Reset: asynchronous, active low; backgrounds clear to zero and the threshold to 50 at once.
// Depends on alsd_pkg, the channel interfaces, alsd_calc and alsd_out_stage.
`default_nettype none
`include "adaptive_line_sensor_detector_defines.svh"

module adaptive_line_sensor_detector import alsd_pkg::*; #(
	parameter int unsigned CAL_READS    = CAL_READS_DEFAULT,
	parameter int unsigned SENSOR_COUNT = SENSOR_COUNT_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	alsd_item_if.sink     item,
	alsd_result_if.source result,
	alsd_cfg_if.sink      cfg
);

	logic             valid_s1;
	item_t            item_s1;
	logic [THR_W-1:0] threshold_q;
	logic [BG_W-1:0]  bg_q   [SENSOR_COUNT];
	logic [BG_W-1:0]  bg_nxt [SENSOR_COUNT];
	result_t          res;
	logic             out_ready;
	logic             adv;

	// The item in the input register moves on, and the store is written, together.
	assign adv        = valid_s1 && out_ready;
	assign item.ready = !valid_s1 || out_ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			threshold_q <= cfg.line_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.action         <= action_t'(item.action);
			item_s1.sensor_index   <= item.sensor_index;
			item_s1.reading_first  <= item.reading_first;
			item_s1.reading_second <= item.reading_second;
			item_s1.reading_third  <= item.reading_third;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
				bg_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < int'(SENSOR_COUNT); i++) begin
				bg_q[i] <= bg_nxt[i];
			end
		end
	end

	alsd_calc #(
		.CAL_READS    (CAL_READS),
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_calc (
		.item_s1   (item_s1),
		.threshold (threshold_q),
		.bg_cur    (bg_q),
		.bg_nxt    (bg_nxt),
		.res       (res)
	);

	alsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (out_ready),
		.in_res   (res),
		.result   (result)
	);

	// A stalled item must stay put until the result register frees up.
	`ALSD_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !adv |=> valid_s1 && $stable(item_s1), "input stage item changed while stalled")
	// Only a detect can ever report a line.
	`ALSD_ASSERT(a_line_detect_only, clk, arst_n, adv && res.line_found |-> item_s1.action == ACT_DETECT, "line reported for an action other than detect")
	// An item addressing no sensor yields an all-zero result.
	`ALSD_ASSERT(a_bad_index_zero, clk, arst_n, adv && (int'(item_s1.sensor_index) >= int'(SENSOR_COUNT)) |-> !res.line_found && (res.background_level == '0), "out-of-range sensor gave a non-zero result")

endmodule

`default_nettype wire
